/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FKLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define FKLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fkls_pkg.sv */
// ----------------------------------------------------------------------------
// fkls_pkg
// shared constants and types of the fixed key lexicographic sorter
// ----------------------------------------------------------------------------
`default_nettype none

package fkls_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int KEY_BYTES = 32;
  localparam int WORD_W    = 64;
  localparam int KEY_W     = 4 * WORD_W;
  localparam int BYTE_CNT  = KEY_W / 8;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic insert;  // store the key on the ports
    logic drain;   // emit the head cell and shift the chain down
  } cmd_t;

  typedef struct packed {
    logic last;    // one key left in the chain
  } stat_t;

endpackage

`default_nettype wire

/* rtl/fkls_ctrl.sv */
// ----------------------------------------------------------------------------
// fkls_ctrl
// load / drain sequencer of the sorter
// ----------------------------------------------------------------------------
`default_nettype none

module fkls_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire logic          final_entry_i,
  input  wire fkls_pkg::stat_t stat_i,
  output fkls_pkg::cmd_t     cmd_o,
  output logic               busy
);
  import fkls_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (start && final_entry_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat_i.last) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.insert = start;
      end
      ST_DRAIN: begin
        cmd_o.drain = 1'b1;
        busy        = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/fkls_dp.sv */
// ----------------------------------------------------------------------------
// fkls_dp
// insertion chain of compare cells with key normalization and result register
// ----------------------------------------------------------------------------
`default_nettype none

module fkls_dp #(
  parameter int DEPTH = fkls_pkg::DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire fkls_pkg::cmd_t               cmd_i,
  output fkls_pkg::stat_t                   stat_o,
  input  wire logic [fkls_pkg::WORD_W-1:0]  key_word0_i,
  input  wire logic [fkls_pkg::WORD_W-1:0]  key_word1_i,
  input  wire logic [fkls_pkg::WORD_W-1:0]  key_word2_i,
  input  wire logic [fkls_pkg::WORD_W-1:0]  key_word3_i,
  output logic                              valid_o,
  output logic [fkls_pkg::WORD_W-1:0]       sorted_word0_o,
  output logic [fkls_pkg::WORD_W-1:0]       sorted_word1_o,
  output logic [fkls_pkg::WORD_W-1:0]       sorted_word2_o,
  output logic [fkls_pkg::WORD_W-1:0]       sorted_word3_o,
  output logic                              last_sorted_o,
  output logic                              overflowed_o
);
  import fkls_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [KEY_W-1:0]    key_raw;
  logic [KEY_W-1:0]    key_n;
  logic [BYTE_CNT-1:0] zero_v;
  logic [KEY_W-1:0]    cell_q [DEPTH];
  logic [DEPTH-1:0]    ins;
  logic [CNT_W-1:0]    count_q;
  logic                ovf_q;
  logic                full;
  logic                valid_q;
  logic                last_q;
  logic                ovf_out_q;
  logic [KEY_W-1:0]    out_q;

  assign key_raw = {key_word0_i, key_word1_i, key_word2_i, key_word3_i};

  // byte b sits at the top end for b = 0; clear past the key length and after the first nul
  always_comb begin
    for (int b = 0; b < BYTE_CNT; b++) begin
      zero_v[b] = (key_raw[KEY_W-1-8*b -: 8] == 8'd0);
    end
    for (int b = 0; b < BYTE_CNT; b++) begin
      if ((b >= KEY_BYTES) || (|(zero_v & ((BYTE_CNT'(1) << b) - BYTE_CNT'(1))))) begin
        key_n[KEY_W-1-8*b -: 8] = 8'd0;
      end else begin
        key_n[KEY_W-1-8*b -: 8] = key_raw[KEY_W-1-8*b -: 8];
      end
    end
  end

  assign full        = (count_q == CNT_W'(DEPTH));
  assign stat_o.last = (count_q == CNT_W'(1));

  // the new key lands at the first cell holding a strictly greater key, else at the tail
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ins[i] = (CNT_W'(i) < count_q) ? (cell_q[i] > key_n) : (CNT_W'(i) == count_q);

    always_ff @(posedge clk_i) begin
      if (cmd_i.drain) begin
        if (i < DEPTH - 1) begin
          cell_q[i] <= cell_q[(i < DEPTH - 1) ? i + 1 : i];
        end
      end else if (cmd_i.insert && !full) begin
        if (i > 0 && ins[(i > 0) ? i - 1 : 0]) begin
          cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
        end else if (ins[i]) begin
          cell_q[i] <= key_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.drain;
      if (cmd_i.drain) begin
        count_q <= count_q - CNT_W'(1);
        if (stat_o.last) begin
          ovf_q <= 1'b0;
        end
      end else if (cmd_i.insert) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.drain) begin
      out_q     <= cell_q[0];
      last_q    <= stat_o.last;
      ovf_out_q <= ovf_q;
    end
  end

  assign valid_o        = valid_q;
  assign sorted_word0_o = out_q[KEY_W-1 -: WORD_W];
  assign sorted_word1_o = out_q[KEY_W-1-WORD_W -: WORD_W];
  assign sorted_word2_o = out_q[KEY_W-1-2*WORD_W -: WORD_W];
  assign sorted_word3_o = out_q[WORD_W-1:0];
  assign last_sorted_o  = last_q;
  assign overflowed_o   = ovf_out_q;

endmodule

`default_nettype wire

/* rtl/fixed_key_lexicographic_sorter.sv */
// ----------------------------------------------------------------------------
// fixed_key_lexicographic_sorter
// collects up to DEPTH text keys and emits them in strcmp order
// ----------------------------------------------------------------------------
// While loading, a key is taken in every cycle in which start is high and busy
// is low; it is normalized and dropped into an insertion chain of DEPTH
// compare cells, so the chain is always sorted. The word with final_entry set
// is stored like the others and then the chain drains from its head: busy
// stays high while the keys held are drained, and one sorted word per cycle
// appears on the result ports with valid_o high for that one cycle. The
// receiver cannot stall, so it must take every strobe. busy drops in the
// cycle that shows the word with last_sorted_o, and a new key may be started
// in that same cycle. Keys beyond DEPTH are dropped and every word of that
// set carries overflowed_o.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_key_lexicographic_sorter #(
  parameter int DEPTH = fkls_pkg::DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [fkls_pkg::WORD_W-1:0]  key_word0_i,
  input  wire logic [fkls_pkg::WORD_W-1:0]  key_word1_i,
  input  wire logic [fkls_pkg::WORD_W-1:0]  key_word2_i,
  input  wire logic [fkls_pkg::WORD_W-1:0]  key_word3_i,
  input  wire logic                         final_entry_i,
  output logic                              valid_o,
  output logic [fkls_pkg::WORD_W-1:0]       sorted_word0_o,
  output logic [fkls_pkg::WORD_W-1:0]       sorted_word1_o,
  output logic [fkls_pkg::WORD_W-1:0]       sorted_word2_o,
  output logic [fkls_pkg::WORD_W-1:0]       sorted_word3_o,
  output logic                              last_sorted_o,
  output logic                              overflowed_o
);
  import fkls_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fkls_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .final_entry_i (final_entry_i),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .busy          (busy)
  );

  fkls_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .key_word0_i    (key_word0_i),
    .key_word1_i    (key_word1_i),
    .key_word2_i    (key_word2_i),
    .key_word3_i    (key_word3_i),
    .valid_o        (valid_o),
    .sorted_word0_o (sorted_word0_o),
    .sorted_word1_o (sorted_word1_o),
    .sorted_word2_o (sorted_word2_o),
    .sorted_word3_o (sorted_word3_o),
    .last_sorted_o  (last_sorted_o),
    .overflowed_o   (overflowed_o)
  );

endmodule

`default_nettype wire

/* rtl/fkls_checker.sv */
// ----------------------------------------------------------------------------
// fkls_checker
// port-level checks of the sorter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fkls_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         final_entry_i,
  input wire logic                         valid_o,
  input wire logic                         last_sorted_o
);

  // a word that is not the last of its run leaves the block busy
  `FKLS_ASSERT_IMP(a_mid_busy, clk_i, rst_ni, valid_o && !last_sorted_o, busy, "mid-run word while idle")

  // the run is contiguous: a non-final word is followed by another word
  `FKLS_ASSERT_NXT(a_run_gapless, clk_i, rst_ni, valid_o && !last_sorted_o, valid_o, "gap inside a sorted run")

  // a final key always starts a drain
  `FKLS_ASSERT_NXT(a_final_drains, clk_i, rst_ni, start && !busy && final_entry_i, busy, "final key did not start output")

  // busy ends only with the last word of the run
  `FKLS_ASSERT_IMP(a_end_on_last, clk_i, rst_ni, $fell(busy), valid_o && last_sorted_o, "busy ended without last word")

endmodule

bind fixed_key_lexicographic_sorter fkls_checker u_fkls_checker (.*);

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fixed key lexicographic sorter
// ----------------------------------------------------------------------------
// Keys are queued up front by an initial block, driven by a falling-edge
// driver and predicted on acceptance. Each finished set is sorted by the bench
// itself and the words that must come out are compared one by one, field by
// field, with what the monitor sees on the result strobe. A directed part
// covers empty and full keys, high bytes, terminators with garbage behind
// them, equal keys and word boundaries. Random sets follow, one of them
// overflowing the store and one filling it exactly.
// ----------------------------------------------------------------------------

module tb_top;

  import fkls_pkg::*;

  localparam int          DEPTH       = DEPTH_DEF;
  localparam int          RAND_ITEMS  = 90;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef logic [0:31][7:0] key_t;  // byte 0 is the most significant

  typedef struct packed {
    key_t key;
    logic final_key;
    logic hold;  // wait until every sorted word is out before driving
  } key_item_t;

  typedef struct packed {
    key_t key;
    logic last_word;
    logic dropped;
  } sorted_key_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [WORD_W-1:0]   key_word0_i;
  logic [WORD_W-1:0]   key_word1_i;
  logic [WORD_W-1:0]   key_word2_i;
  logic [WORD_W-1:0]   key_word3_i;
  logic                final_entry_i;
  logic                valid_o;
  logic [WORD_W-1:0]   sorted_word0_o;
  logic [WORD_W-1:0]   sorted_word1_o;
  logic [WORD_W-1:0]   sorted_word2_o;
  logic [WORD_W-1:0]   sorted_word3_o;
  logic                last_sorted_o;
  logic                overflowed_o;

  key_item_t   pending_keys[$];
  sorted_key_t sorted_expect[$];
  key_t        recent_keys[$];
  key_t        held_keys[DEPTH];
  int          held_count;
  logic        keys_dropped;
  bit          took_word;
  int          accepted_cnt;
  int          mismatches;
  int unsigned cycle_cnt;

  fixed_key_lexicographic_sorter #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .key_word0_i   (key_word0_i),
    .key_word1_i   (key_word1_i),
    .key_word2_i   (key_word2_i),
    .key_word3_i   (key_word3_i),
    .final_entry_i (final_entry_i),
    .valid_o       (valid_o),
    .sorted_word0_o(sorted_word0_o),
    .sorted_word1_o(sorted_word1_o),
    .sorted_word2_o(sorted_word2_o),
    .sorted_word3_o(sorted_word3_o),
    .last_sorted_o (last_sorted_o),
    .overflowed_o  (overflowed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // clear bytes past the key length and everything after the first zero byte
  function automatic key_t trim_key(key_t raw);
    key_t k;
    logic ended;
    k     = raw;
    ended = 1'b0;
    for (int b = 0; b < 32; b++) begin
      if (b >= KEY_BYTES || ended) begin
        k[b] = 8'h00;
      end else if (k[b] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return k;
  endfunction

  function automatic key_t text_key(string s);
    key_t k;
    k = '0;
    for (int i = 0; i < s.len() && i < 32; i++) k[i] = s[i];
    return k;
  endfunction

  function automatic key_t rand_key();
    key_t k;
    int   len;
    int   pick;
    k    = '0;
    pick = $urandom_range(0, 9);
    if (pick == 9) begin
      // raw bytes, terminated wherever a zero happens to land
      for (int b = 0; b < 32; b++) k[b] = 8'($urandom_range(0, 255));
      return k;
    end
    if (pick >= 7 && recent_keys.size() != 0) begin
      k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      // near miss of an earlier key, or an exact duplicate
      if (pick == 8) k[5'($urandom_range(0, 31))] = 8'($urandom_range(1, 255));
      return k;
    end
    len = (pick < 4) ? $urandom_range(0, 6) : $urandom_range(0, 32);
    for (int b = 0; b < len; b++) begin
      k[b] = (pick < 4) ? 8'($urandom_range(8'h61, 8'h63)) : 8'($urandom_range(1, 255));
    end
    if (len < 31 && $urandom_range(0, 1)) begin
      for (int b = len + 1; b < 32; b++) k[b] = 8'($urandom_range(0, 255));
    end
    return k;
  endfunction

  task automatic add_key(input key_t k, input bit fin, input bit hold);
    key_item_t item;
    item.key       = k;
    item.final_key = fin;
    item.hold      = hold;
    pending_keys.push_back(item);
    recent_keys.push_back(k);
    if (recent_keys.size() > 16) void'(recent_keys.pop_front());
  endtask

  // store one accepted key; on the last key of a set, sort and queue the run
  task automatic store_key(input key_item_t item);
    key_t        order[DEPTH];
    key_t        k;
    sorted_key_t res;
    int          j;
    if (held_count < DEPTH) begin
      held_keys[held_count] = trim_key(item.key);
      held_count++;
    end else begin
      keys_dropped = 1'b1;
    end
    if (item.final_key) begin
      // stable insertion sort keeps equal keys in arrival order
      for (int i = 0; i < held_count; i++) begin
        k = held_keys[i];
        j = i;
        while (j > 0 && order[j-1] > k) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = k;
      end
      for (int i = 0; i < held_count; i++) begin
        res.key       = order[i];
        res.last_word = (i == held_count - 1);
        res.dropped   = keys_dropped;
        sorted_expect.push_back(res);
      end
      held_count   = 0;
      keys_dropped = 1'b0;
    end
  endtask

  // stimulus and end of run
  initial begin
    key_t base;
    key_t k;
    int   set_no;
    int   set_len;
    int   rand_items;

    rst_ni        = 1'b0;
    start         = 1'b0;
    key_word0_i   = '0;
    key_word1_i   = '0;
    key_word2_i   = '0;
    key_word3_i   = '0;
    final_entry_i = 1'b0;
    held_count    = 0;
    keys_dropped  = 1'b0;
    took_word     = 1'b0;
    accepted_cnt  = 0;
    mismatches    = 0;

    // extremes of the byte range, terminators and garbage after them
    add_key('0, 1'b0, 1'b0);
    add_key('1, 1'b0, 1'b0);
    add_key(text_key("a"), 1'b0, 1'b0);
    add_key(text_key("ab"), 1'b0, 1'b0);
    k = text_key("a");
    for (int b = 2; b < 32; b++) k[b] = 8'($urandom_range(0, 255));
    add_key(k, 1'b0, 1'b0);
    k = '0;
    for (int b = 1; b < 32; b++) k[b] = 8'($urandom_range(0, 255));
    add_key(k, 1'b0, 1'b0);
    k = '0;
    k[0] = 8'h80;
    add_key(k, 1'b0, 1'b0);
    k = '0;
    k[0] = 8'h7f;
    k[1] = 8'hff;
    add_key(k, 1'b0, 1'b0);
    for (int b = 0; b < 32; b++) k[b] = 8'h7a;
    k[31] = 8'h01;
    add_key(k, 1'b1, 1'b0);

    // single-key set, sent only after the previous run is fully out
    for (int b = 0; b < 32; b++) k[b] = 8'($urandom_range(1, 255));
    add_key(k, 1'b1, 1'b1);

    // differences right at and around the word boundaries, plus a duplicate
    for (int b = 0; b < 32; b++) base[b] = 8'h6d;
    k = base; k[31] = 8'h6e; add_key(k, 1'b0, 1'b1);
    k = base; k[24] = 8'h6e; add_key(k, 1'b0, 1'b0);
    k = base; k[16] = 8'h6e; add_key(k, 1'b0, 1'b0);
    k = base; k[8]  = 8'h6e; add_key(k, 1'b0, 1'b0);
    k = base; k[7]  = 8'h6c; add_key(k, 1'b0, 1'b0);
    add_key(base, 1'b0, 1'b0);
    add_key(base, 1'b1, 1'b0);

    // random sets; one overflows with its last two keys dropped, one fills exactly
    set_no     = 0;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      if (set_no == 2) set_len = DEPTH + 2;
      else if (set_no == 6) set_len = DEPTH;
      else set_len = $urandom_range(1, 10);
      for (int i = 0; i < set_len; i++) add_key(rand_key(), i == set_len - 1, 1'b0);
      rand_items += set_len;
      set_no++;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_keys.size() != 0 || sorted_expect.size() != 0) @(posedge clk_i);
    repeat (2 * DEPTH) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // driver: new word or idle at the falling edge once the last one was taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || took_word) begin
      took_word = 1'b0;
      if (pending_keys.size() == 0 ||
          (pending_keys[0].hold && (sorted_expect.size() != 0 || busy)) ||
          (!(accepted_cnt >= 60 && accepted_cnt < 100) && $urandom_range(0, 99) < 20)) begin
        start         <= 1'b0;
        key_word0_i   <= {$urandom, $urandom};
        key_word1_i   <= {$urandom, $urandom};
        key_word2_i   <= {$urandom, $urandom};
        key_word3_i   <= {$urandom, $urandom};
        final_entry_i <= 1'($urandom_range(0, 1));
      end else begin
        start         <= 1'b1;
        key_word0_i   <= pending_keys[0].key[0:7];
        key_word1_i   <= pending_keys[0].key[8:15];
        key_word2_i   <= pending_keys[0].key[16:23];
        key_word3_i   <= pending_keys[0].key[24:31];
        final_entry_i <= pending_keys[0].final_key;
      end
    end
  end

  // monitor and acceptance at the rising edge
  always @(posedge clk_i) begin
    logic [0:3][WORD_W-1:0] got_words;
    sorted_key_t            want;
    if (rst_ni) begin
      if (valid_o) begin
        got_words = {sorted_word0_o, sorted_word1_o, sorted_word2_o, sorted_word3_o};
        if (sorted_expect.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h last %b ovf %b",
                   $time, got_words, last_sorted_o, overflowed_o);
          mismatches++;
        end else begin
          want = sorted_expect.pop_front();
          for (int w = 0; w < 4; w++) begin
            if (got_words[w] !== want.key[w*8 +: 8]) begin
              $display("%0t: sorted_word%0d expected %h got %h",
                       $time, w, want.key[w*8 +: 8], got_words[w]);
              mismatches++;
            end
          end
          if (last_sorted_o !== want.last_word) begin
            $display("%0t: last_sorted expected %b got %b",
                     $time, want.last_word, last_sorted_o);
            mismatches++;
          end
          if (overflowed_o !== want.dropped) begin
            $display("%0t: overflowed expected %b got %b",
                     $time, want.dropped, overflowed_o);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        store_key(pending_keys.pop_front());
        took_word = 1'b1;
        accepted_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial cycle_cnt = 0;

endmodule

/* filelist.f */
+incdir+rtl
rtl/fkls_pkg.sv
rtl/fkls_ctrl.sv
rtl/fkls_dp.sv
rtl/fixed_key_lexicographic_sorter.sv
rtl/fkls_checker.sv
bench/tb_top.sv
